>>> rtl/core/sdec_pkg.sv
// ----------------------------------------------------------------------------
// Snappy decompressor package
// Shared types, status codes and command layout for the front and back parts.
// ----------------------------------------------------------------------------
package sdec_pkg;

  // Block status codes carried on the final result of a block.
  localparam logic [2:0] STAT_RUN      = 3'd0;
  localparam logic [2:0] STAT_OK       = 3'd1;
  localparam logic [2:0] STAT_TRUNC    = 3'd2;
  localparam logic [2:0] STAT_OFFSET   = 3'd3;
  localparam logic [2:0] STAT_LENGTH   = 3'd4;
  localparam logic [2:0] STAT_PREAMBLE = 3'd5;

  // Command kinds passed from the parser to the output engine.
  localparam logic [1:0] CMD_STAT = 2'd0;
  localparam logic [1:0] CMD_LIT  = 2'd1;
  localparam logic [1:0] CMD_COPY = 2'd2;

  // Command queue depth.
  localparam int QDepth = 4;
  localparam int QAw    = 2;

  // Largest value of a 31-bit length.
  localparam logic [30:0] LenMax = 31'h7fffffff;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] off;
    logic [6:0]  len;
    logic        eob;
    logic [2:0]  status;
  } sdec_cmd_t;

  // Number of extra bytes that follow a tag byte.
  function automatic logic [2:0] extra_needed(input logic [7:0] tag);
    logic [2:0] n;
    case (tag[1:0])
      2'd0:    n = 3'(tag[7:2] - 6'd59);
      2'd1:    n = 3'd1;
      2'd2:    n = 3'd2;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/core/sdec_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sdec_ram #(
  parameter int Width = 8,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/sdec_front.sv
// ----------------------------------------------------------------------------
// Snappy decompressor parser
// Decodes the length preamble and the tags, runs all checks, and issues one
// command per compressed byte at most.
// ----------------------------------------------------------------------------
module sdec_front import sdec_pkg::*; #(
  parameter int WindowSize = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_data_i,
  input  logic        in_acc_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_eob_i,
  output logic        push_o,
  output sdec_cmd_t   cmd_o
);

  localparam logic [2:0] PH_PRE   = 3'd0;
  localparam logic [2:0] PH_TAG   = 3'd1;
  localparam logic [2:0] PH_EXTRA = 3'd2;
  localparam logic [2:0] PH_LIT   = 3'd3;
  localparam logic [2:0] PH_DRAIN = 3'd4;

  logic [30:0] max_q, exp_q, exp_d, prod_q, prod_d, lrem_q, lrem_d;
  logic [2:0]  phase_q, phase_d, err_q, err_d, xrem_q, xrem_d;
  logic [7:0]  tag_q, tag_d;
  logic [31:0] xval_q, xval_d, xval_new, off;
  logic [1:0]  xidx_q, xidx_d;
  logic [5:0]  shift_q, shift_d;
  logic [6:0]  g, cp_len;
  logic [37:0] total;
  logic [32:0] lit_len;
  logic        start_lit;
  logic [2:0]  st;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= LenMax;
    end else if (cfg_we_i) begin
      max_q <= cfg_data_i;
    end
  end

  // Parser next state and command generation.
  always_comb begin
    exp_d     = exp_q;
    prod_d    = prod_q;
    lrem_d    = lrem_q;
    phase_d   = phase_q;
    err_d     = err_q;
    xrem_d    = xrem_q;
    tag_d     = tag_q;
    xval_d    = xval_q;
    xidx_d    = xidx_q;
    shift_d   = shift_q;
    push_o    = 1'b0;
    cmd_o     = '0;
    g         = in_byte_i[6:0];
    total     = {7'd0, exp_q} | ({31'd0, g} << shift_q);
    xval_new  = xval_q | ({24'd0, in_byte_i} << {xidx_q, 3'b000});
    lit_len   = '0;
    start_lit = 1'b0;
    off       = '0;
    cp_len    = '0;
    st        = STAT_RUN;
    if (in_acc_i) begin
      case (phase_q)
        PH_PRE: begin
          if (g != 7'd0 && (shift_q >= 6'd31 || total > 38'h7fffffff)) begin
            err_d   = STAT_PREAMBLE;
            phase_d = PH_DRAIN;
          end else begin
            if (g != 7'd0) begin
              exp_d = total[30:0];
            end
            if (in_byte_i[7]) begin
              if (shift_q < 6'd35) begin
                shift_d = shift_q + 6'd7;
              end
            end else if (exp_d == 31'd0 || exp_d > max_q) begin
              err_d   = STAT_PREAMBLE;
              phase_d = PH_DRAIN;
            end else begin
              phase_d = PH_TAG;
            end
          end
        end
        PH_TAG: begin
          tag_d = in_byte_i;
          if (in_byte_i[1:0] == 2'd0 && in_byte_i[7:2] < 6'd60) begin
            start_lit = 1'b1;
            lit_len   = {27'd0, in_byte_i[7:2]} + 33'd1;
          end else begin
            xval_d  = '0;
            xidx_d  = '0;
            xrem_d  = extra_needed(in_byte_i);
            phase_d = PH_EXTRA;
          end
        end
        PH_EXTRA: begin
          xval_d = xval_new;
          xrem_d = xrem_q - 3'd1;
          xidx_d = xidx_q + 2'd1;
          if (xrem_q == 3'd1) begin
            if (tag_q[1:0] == 2'd0) begin
              start_lit = 1'b1;
              lit_len   = {1'b0, xval_new} + 33'd1;
            end else begin
              // Copy: work out offset and length, then check them.
              if (tag_q[1:0] == 2'd1) begin
                off    = {21'd0, tag_q[7:5], xval_new[7:0]};
                cp_len = {4'd0, tag_q[4:2]} + 7'd4;
              end else begin
                off    = xval_new;
                cp_len = {1'b0, tag_q[7:2]} + 7'd1;
              end
              if (off > 32'hffff || off == 32'd0 || off > {1'b0, prod_q}
                  || off > 32'(WindowSize)) begin
                err_d   = STAT_OFFSET;
                phase_d = PH_DRAIN;
              end else if ({1'b0, prod_q} + {25'd0, cp_len} > {1'b0, exp_q}) begin
                err_d   = STAT_LENGTH;
                phase_d = PH_DRAIN;
              end else begin
                push_o     = 1'b1;
                cmd_o.kind = CMD_COPY;
                cmd_o.off  = off[15:0];
                cmd_o.len  = cp_len;
                prod_d     = prod_q + {24'd0, cp_len};
                phase_d    = PH_TAG;
              end
            end
          end
        end
        PH_LIT: begin
          push_o     = 1'b1;
          cmd_o.kind = CMD_LIT;
          cmd_o.data = in_byte_i;
          prod_d     = prod_q + 31'd1;
          lrem_d     = lrem_q - 31'd1;
          if (lrem_q == 31'd1) begin
            phase_d = PH_TAG;
          end
        end
        default: begin
        end
      endcase

      // Literal start with its length check.
      if (start_lit) begin
        if (lit_len > 33'h7fffffff
            || {3'd0, prod_q} + {1'b0, lit_len} > {3'd0, exp_q}) begin
          err_d   = STAT_LENGTH;
          phase_d = PH_DRAIN;
        end else begin
          lrem_d  = lit_len[30:0];
          phase_d = PH_LIT;
        end
      end

      // End of block: attach the status and clear the block state.
      if (in_eob_i) begin
        if (err_d != STAT_RUN) begin
          st = err_d;
        end else if (phase_d != PH_TAG) begin
          st = STAT_TRUNC;
        end else if (prod_d != exp_d) begin
          st = STAT_LENGTH;
        end else begin
          st = STAT_OK;
        end
        if (!push_o) begin
          push_o     = 1'b1;
          cmd_o      = '0;
          cmd_o.kind = CMD_STAT;
        end
        cmd_o.eob    = 1'b1;
        cmd_o.status = st;
        exp_d   = '0;
        prod_d  = '0;
        lrem_d  = '0;
        phase_d = PH_PRE;
        err_d   = STAT_RUN;
        xrem_d  = '0;
        tag_d   = '0;
        xval_d  = '0;
        xidx_d  = '0;
        shift_d = '0;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q   <= '0;
      prod_q  <= '0;
      lrem_q  <= '0;
      phase_q <= PH_PRE;
      err_q   <= STAT_RUN;
      xrem_q  <= '0;
      tag_q   <= '0;
      xval_q  <= '0;
      xidx_q  <= '0;
      shift_q <= '0;
    end else begin
      exp_q   <= exp_d;
      prod_q  <= prod_d;
      lrem_q  <= lrem_d;
      phase_q <= phase_d;
      err_q   <= err_d;
      xrem_q  <= xrem_d;
      tag_q   <= tag_d;
      xval_q  <= xval_d;
      xidx_q  <= xidx_d;
      shift_q <= shift_d;
    end
  end

endmodule

>>> rtl/core/sdec_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Snappy decompressor command queue
// A short queue between the parser and the output engine.
// ----------------------------------------------------------------------------
module sdec_cmd_fifo import sdec_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sdec_cmd_t cmd_i,
  input  logic      pop_i,
  output sdec_cmd_t cmd_o,
  output logic      empty_o,
  output logic      full_o
);

  sdec_cmd_t        slot_q [QDepth];
  logic [QAw-1:0]   wptr_q, rptr_q;
  logic [QAw:0]     cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QAw+1)'(QDepth));
  assign cmd_o   = slot_q[rptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/sdec_back.sv
// ----------------------------------------------------------------------------
// Snappy decompressor output engine
// Carries out commands: writes literal bytes to history, replays copies byte
// by byte, and drives the output register.
// ----------------------------------------------------------------------------
module sdec_back import sdec_pkg::*; #(
  parameter int WindowSize = 65536
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sdec_cmd_t cmd_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic [7:0] out_byte_o,
  output logic      out_bv_o,
  output logic      out_last_o,
  output logic [2:0] out_status_o
);

  localparam int Aw = $clog2(WindowSize);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [Aw-1:0] wptr_q, wptr_d, off_q, off_d;
  logic [6:0]    cnt_q, cnt_d;
  logic [2:0]    stat_q, stat_d;
  logic          ov_q, ov_d, obv_q, obv_d, olast_q, olast_d;
  logic [7:0]    obyte_q, obyte_d;
  logic [2:0]    ostat_q, ostat_d;
  logic          out_free, we, re;
  logic [7:0]    wdata, rdata;
  logic [Aw-1:0] raddr;

  assign out_free = !ov_q || out_ready_i;

  sdec_ram #(.Width(8), .Depth(WindowSize)) u_hist (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wptr_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Command execution.
  always_comb begin
    state_d = state_q;
    wptr_d  = wptr_q;
    off_d   = off_q;
    cnt_d   = cnt_q;
    stat_d  = stat_q;
    ov_d    = ov_q && !out_ready_i;
    obv_d   = obv_q;
    olast_d = olast_q;
    obyte_d = obyte_q;
    ostat_d = ostat_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    wdata   = cmd_i.data;
    re      = 1'b0;
    raddr   = wptr_q - off_q;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          if (cmd_i.kind == CMD_COPY) begin
            pop_o   = 1'b1;
            off_d   = cmd_i.off[Aw-1:0];
            cnt_d   = cmd_i.len;
            stat_d  = cmd_i.status;
            state_d = S_ISSUE;
          end else if (out_free) begin
            // A literal byte or a status-only result is the only result of
            // its input byte.
            pop_o   = 1'b1;
            ov_d    = 1'b1;
            olast_d = 1'b1;
            ostat_d = cmd_i.status;
            if (cmd_i.kind == CMD_LIT) begin
              we      = 1'b1;
              wptr_d  = wptr_q + 1'b1;
              obv_d   = 1'b1;
              obyte_d = cmd_i.data;
            end else begin
              obv_d   = 1'b0;
              obyte_d = '0;
            end
          end
        end
      end
      S_ISSUE: begin
        re      = 1'b1;
        state_d = S_READ;
      end
      S_READ: begin
        if (out_free) begin
          we      = 1'b1;
          wdata   = rdata;
          wptr_d  = wptr_q + 1'b1;
          cnt_d   = cnt_q - 7'd1;
          ov_d    = 1'b1;
          obv_d   = 1'b1;
          obyte_d = rdata;
          olast_d = (cnt_q == 7'd1);
          ostat_d = (cnt_q == 7'd1) ? stat_q : STAT_RUN;
          state_d = (cnt_q == 7'd1) ? S_IDLE : S_ISSUE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wptr_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      wptr_q  <= wptr_d;
      ov_q    <= ov_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    off_q   <= off_d;
    cnt_q   <= cnt_d;
    stat_q  <= stat_d;
    obv_q   <= obv_d;
    olast_q <= olast_d;
    obyte_q <= obyte_d;
    ostat_q <= ostat_d;
  end

  assign out_valid_o  = ov_q;
  assign out_byte_o   = obyte_q;
  assign out_bv_o     = obv_q;
  assign out_last_o   = olast_q;
  assign out_status_o = ostat_q;

endmodule

>>> rtl/core/snappy_raw_decompressor.sv
// ----------------------------------------------------------------------------
// Snappy raw block decompressor
// Takes compressed bytes on the slave stream and returns decompressed bytes
// on the master stream.
//
// s_axis carries one compressed byte per item; tlast marks the final byte of
// a block. m_axis returns results: tdata is the byte, tuser holds byte_valid
// and the status, tlast marks the last result caused by one input byte. The
// final result of a block carries its status, or is a status-only result.
// The parser takes one byte per cycle while its four-entry command queue has
// room. A literal byte enters the output register in the cycle after it is
// taken from the queue; each byte of a copy passes the issue state, which
// reads the history RAM, and the read state, which takes the registered
// data. A stalled receiver holds the output register; the queue then fills
// and the input stalls. Reset clears all control state and sets
// max_output_length to its largest value; history needs no clearing.
// ----------------------------------------------------------------------------
module snappy_raw_decompressor import sdec_pkg::*; #(
  parameter int WINDOW_SIZE = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_data_i,      // max_output_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // [7:0] out_byte
  output logic [3:0]  m_axis_tuser,    // [0] byte_valid, [3:1] status
  output logic        m_axis_tlast
);

  logic      full, empty, push, pop, in_acc;
  sdec_cmd_t cmd_in, cmd_out;
  logic [2:0] status;
  logic       bv;

  assign s_axis_tready = !full;
  assign in_acc        = s_axis_tvalid && !full;

  sdec_front #(.WindowSize(WINDOW_SIZE)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_acc_i   (in_acc),
    .in_byte_i  (s_axis_tdata),
    .in_eob_i   (s_axis_tlast),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  sdec_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .empty_o (empty),
    .full_o  (full)
  );

  sdec_back #(.WindowSize(WINDOW_SIZE)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_out),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_bv_o     (bv),
    .out_last_o   (m_axis_tlast),
    .out_status_o (status)
  );

  assign m_axis_tuser = {status, bv};

  // A result with a status is always the last result of its input byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status != STAT_RUN |-> m_axis_tlast)
    else $error("status on a result that is not last");

  // A status-only result always carries a final status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !bv |-> status != STAT_RUN && m_axis_tlast)
    else $error("status-only result without status");

  // The queue is never pushed while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push)
    else $error("command queue overflow");

endmodule
